// ----- hdl/rqp_pkg.sv -----
// Shared constants, register codes and stage counts for the radial quadrature point block.
package rqp_pkg;

	localparam int DEF_MAX_POINTS = 4096;
	localparam int DEF_MAX_ORDER  = 8;

	localparam int GRID_W  = 13;
	localparam int ORDER_W = 4;
	localparam int SCALE_W = 32;
	localparam int INDEX_W = 12;
	localparam int CFG_W   = 32;

	localparam int RADIUS_W = 48;
	localparam int WEIGHT_W = 63;

	localparam logic [GRID_W-1:0]  GRID_RST  = 13'd64;
	localparam logic [ORDER_W-1:0] ORDER_RST = 4'd3;
	localparam logic [SCALE_W-1:0] SCALE_RST = 32'h0100_0000;
	localparam logic [35:0]        MSCALE_RST = 36'h0_0300_0000;

	// log2 fraction bits and the width of -log2(a) in Q6.40
	localparam int LOG_BITS = 40;
	localparam int NLOG_W   = 6 + LOG_BITS;

	localparam logic [63:0] LN2_Q64 = 64'hB172_17F7_D1CF_79AB;
	localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

	localparam logic [RADIUS_W-1:0] RADIUS_MAX = '1;
	localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = '1;

	// divider shapes: point divide 44 bits at 4/stage, weight divide 64 bits at 2/stage
	localparam int DIVX_NB  = 44;
	localparam int DIVX_SPS = 4;
	localparam int DIVX_STG = DIVX_NB / DIVX_SPS;
	localparam int DIVW_NB  = 64;
	localparam int DIVW_SPS = 2;
	localparam int DIVW_STG = DIVW_NB / DIVW_SPS;
	localparam int D_W      = 46;

	// leading-one stage, two stages per squaring, final subtract
	localparam int LOG_STG = 2 * LOG_BITS + 2;

	typedef enum logic [1:0] {
		REG_GRID_SIZE    = 2'd0,
		REG_POWER_ORDER  = 2'd1,
		REG_RADIAL_SCALE = 2'd2
	} reg_index_t;

endpackage

// ----- hdl/rqp_div.sv -----
// Pipelined restoring divider, several quotient bits per stage, with a side channel.
module rqp_div #(
	parameter int NB  = 44,
	parameter int VW  = 13,
	parameter int SPS = 4,
	parameter int SW  = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [VW-1:0] rem_in,
	input  logic [NB-1:0] bits_in,
	input  logic [VW-1:0] divisor,
	input  logic [SW-1:0] side_in,
	output logic          out_valid,
	output logic [NB-1:0] quot,
	output logic [SW-1:0] side_out
);
	localparam int STG = NB / SPS;

	// index 0 is the input, index i+1 the register of stage i
	logic          v_s   [STG+1];
	logic [VW-1:0] rem_s [STG+1];
	logic [NB-1:0] w_s   [STG+1];
	logic [VW-1:0] dv_s  [STG+1];
	logic [SW-1:0] sd_s  [STG+1];

	assign v_s[0]   = in_valid;
	assign rem_s[0] = rem_in;
	assign w_s[0]   = bits_in;
	assign dv_s[0]  = divisor;
	assign sd_s[0]  = side_in;

	for (genvar i = 0; i < STG; i++) begin : g_stage
		logic [VW-1:0] r;
		logic [NB-1:0] w;
		logic [VW:0]   t;

		// dividend bits leave the top of w while quotient bits enter at the bottom
		always_comb begin
			r = rem_s[i];
			w = w_s[i];
			t = '0;
			for (int j = 0; j < SPS; j++) begin
				t = {r, w[NB-1]};
				w = {w[NB-2:0], 1'b0};
				if (t >= {1'b0, dv_s[i]}) begin
					t = t - {1'b0, dv_s[i]};
					w[0] = 1'b1;
				end
				r = t[VW-1:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[i+1] <= r;
			w_s[i+1]   <= w;
			dv_s[i+1]  <= dv_s[i];
			sd_s[i+1]  <= sd_s[i];
		end
	end

	assign out_valid = v_s[STG];
	assign quot      = w_s[STG];
	assign side_out  = sd_s[STG];

endmodule

// ----- hdl/rqp_log.sv -----
// Pipelined -log2 of a Q1.32 value by repeated squaring, two stages per result bit.
module rqp_log #(
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [32:0]   a,
	input  logic [SW-1:0] in_side,
	output logic          out_valid,
	output logic [45:0]   nlog,
	output logic [SW-1:0] out_side
);
	import rqp_pkg::*;

	logic [5:0]  lead_k;
	logic [63:0] lead_y;

	always_comb begin
		lead_k = '0;
		for (int b = 0; b < 33; b++) begin
			if (a[b]) begin
				lead_k = 6'(b);
			end
		end
		lead_y = {31'b0, a} << (6'd63 - lead_k);
	end

	// squaring state: index 0 is the normalize register
	logic                bv_s  [LOG_BITS+1];
	logic [63:0]         y_s   [LOG_BITS+1];
	logic [LOG_BITS-1:0] fr_s  [LOG_BITS+1];
	logic [5:0]          k_s   [LOG_BITS+1];
	logic [SW-1:0]       sd_s  [LOG_BITS+1];

	// partial products of each squaring
	logic                av_s  [LOG_BITS];
	logic [63:0]         hh_s  [LOG_BITS];
	logic [63:0]         hl_s  [LOG_BITS];
	logic [63:0]         ll_s  [LOG_BITS];
	logic [LOG_BITS-1:0] afr_s [LOG_BITS];
	logic [5:0]          ak_s  [LOG_BITS];
	logic [SW-1:0]       asd_s [LOG_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bv_s[0] <= 1'b0;
		end else begin
			bv_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		y_s[0]  <= lead_y;
		fr_s[0] <= '0;
		k_s[0]  <= lead_k;
		sd_s[0] <= in_side;
	end

	for (genvar i = 0; i < LOG_BITS; i++) begin : g_sq
		logic [127:0] p;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				av_s[i]   <= 1'b0;
				bv_s[i+1] <= 1'b0;
			end else begin
				av_s[i]   <= bv_s[i];
				bv_s[i+1] <= av_s[i];
			end
		end

		always_ff @(posedge clk) begin
			hh_s[i]  <= 64'(y_s[i][63:32]) * 64'(y_s[i][63:32]);
			hl_s[i]  <= 64'(y_s[i][63:32]) * 64'(y_s[i][31:0]);
			ll_s[i]  <= 64'(y_s[i][31:0]) * 64'(y_s[i][31:0]);
			afr_s[i] <= fr_s[i];
			ak_s[i]  <= k_s[i];
			asd_s[i] <= sd_s[i];
		end

		assign p = {hh_s[i], 64'b0} + {31'b0, hl_s[i], 33'b0} + {64'b0, ll_s[i]};

		// square at or above two: emit a one and halve
		always_ff @(posedge clk) begin
			if (p[127]) begin
				y_s[i+1]  <= p[127:64];
				fr_s[i+1] <= {afr_s[i][LOG_BITS-2:0], 1'b1};
			end else begin
				y_s[i+1]  <= p[126:63];
				fr_s[i+1] <= {afr_s[i][LOG_BITS-2:0], 1'b0};
			end
			k_s[i+1]  <= ak_s[i];
			sd_s[i+1] <= asd_s[i];
		end
	end

	logic              fv_q;
	logic [NLOG_W-1:0] nl_q;
	logic [SW-1:0]     fsd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fv_q <= 1'b0;
		end else begin
			fv_q <= bv_s[LOG_BITS];
		end
	end

	always_ff @(posedge clk) begin
		nl_q  <= {6'd32 - k_s[LOG_BITS], {LOG_BITS{1'b0}}}
			- {6'b0, fr_s[LOG_BITS]};
		fsd_q <= sd_s[LOG_BITS];
	end

	assign out_valid = fv_q;
	assign nlog      = 46'(nl_q);
	assign out_side  = fsd_q;

endmodule

// ----- hdl/radial_quadrature_point.sv -----
// Mura-Knowles radial grid point: one index per clock in, one radius/weight/saturated out;
// the 40 squarings of the logarithm and the 64-bit weight divide make up most of the pipeline.
// busy never rises, and each result shows for one cycle with done; it cannot be held.
module radial_quadrature_point #(
	parameter int MAX_POINTS = rqp_pkg::DEF_MAX_POINTS,
	parameter int MAX_ORDER  = rqp_pkg::DEF_MAX_ORDER
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wen,
	input  logic [1:0]                     cfg_index,
	input  logic [rqp_pkg::CFG_W-1:0]      cfg_wdata,
	input  logic                           start,
	input  logic [rqp_pkg::INDEX_W-1:0]    point_index,
	output logic                           busy,
	output logic                           done,
	output logic [rqp_pkg::RADIUS_W-1:0]   radius,
	output logic [rqp_pkg::WEIGHT_W-1:0]   weight,
	output logic                           saturated
);
	import rqp_pkg::*;

	localparam int LAT = 1 + DIVX_STG + MAX_ORDER + 1 + LOG_STG + 10 + DIVW_STG + 1;

	// ---------------- configuration ----------------
	logic [GRID_W-1:0]  grid_size_q;
	logic [ORDER_W-1:0] power_order_q;
	logic [SCALE_W-1:0] radial_scale_q;
	logic [35:0]        mscale_q;       // m * alpha, used deep in the pipe

	logic [GRID_W-1:0]  big_n;
	logic [ORDER_W-1:0] m_lo;
	logic [ORDER_W-1:0] m_eff;

	always_comb begin
		big_n = (32'(grid_size_q) > MAX_POINTS) ? GRID_W'(MAX_POINTS) : grid_size_q;
		m_lo  = (power_order_q == '0) ? ORDER_W'(1) : power_order_q;
		m_eff = (32'(m_lo) > MAX_ORDER) ? ORDER_W'(MAX_ORDER) : m_lo;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_size_q    <= GRID_RST;
			power_order_q  <= ORDER_RST;
			radial_scale_q <= SCALE_RST;
			mscale_q       <= MSCALE_RST;
		end else begin
			if (cfg_wen) begin
				case (reg_index_t'(cfg_index))
					REG_GRID_SIZE:    grid_size_q    <= cfg_wdata[GRID_W-1:0];
					REG_POWER_ORDER:  power_order_q  <= cfg_wdata[ORDER_W-1:0];
					REG_RADIAL_SCALE: radial_scale_q <= cfg_wdata[SCALE_W-1:0];
					default: ;
				endcase
			end
			mscale_q <= 36'(m_eff) * 36'(radial_scale_q);
		end
	end

	// every cycle takes a request
	assign busy = 1'b0;

	// ---------------- entry ----------------
	logic               v_s1;
	logic [INDEX_W-1:0] n_s1;
	logic               oob_s1;   // index at or past the grid end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		n_s1   <= point_index;
		oob_s1 <= {1'b0, point_index} >= big_n;
	end

	// ---------------- x = (2n+1) * 2^31 / N ----------------
	logic               dx_v;
	logic [DIVX_NB-1:0] dx_q;
	logic               dx_oob;

	rqp_div #(
		.NB (DIVX_NB),
		.VW (GRID_W),
		.SPS(DIVX_SPS),
		.SW (1)
	) u_divx (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(v_s1),
		.rem_in  ('0),
		.bits_in ({n_s1, 1'b1, 31'b0}),
		.divisor (big_n),
		.side_in (oob_s1),
		.out_valid(dx_v),
		.quot    (dx_q),
		.side_out(dx_oob)
	);

	// ---------------- x^(m-1), one product per stage ----------------
	logic        v_s2   [MAX_ORDER];
	logic [31:0] x_s2   [MAX_ORDER];
	logic [32:0] xp_s2  [MAX_ORDER];
	logic        oob_s2 [MAX_ORDER];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2[0] <= 1'b0;
		end else begin
			v_s2[0] <= dx_v;
		end
	end

	always_ff @(posedge clk) begin
		x_s2[0]   <= dx_q[31:0];
		xp_s2[0]  <= ONE_Q32;
		oob_s2[0] <= dx_oob;
	end

	for (genvar j = 1; j < MAX_ORDER; j++) begin : g_pow
		logic [64:0] pr;
		assign pr = 65'(xp_s2[j-1]) * 65'(x_s2[j-1]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s2[j] <= 1'b0;
			end else begin
				v_s2[j] <= v_s2[j-1];
			end
		end

		always_ff @(posedge clk) begin
			x_s2[j]   <= x_s2[j-1];
			xp_s2[j]  <= (32'(j) < 32'(m_eff)) ? pr[64:32] : xp_s2[j-1];
			oob_s2[j] <= oob_s2[j-1];
		end
	end

	// ---------------- a = 1 - x^m ----------------
	logic        v_s3;
	logic [32:0] a_s3;
	logic [32:0] xp_s3;
	logic        oob_s3;
	logic [64:0] xm_full;

	assign xm_full = 65'(xp_s2[MAX_ORDER-1]) * 65'(x_s2[MAX_ORDER-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2[MAX_ORDER-1];
		end
	end

	always_ff @(posedge clk) begin
		a_s3   <= ONE_Q32 - xm_full[64:32];
		xp_s3  <= xp_s2[MAX_ORDER-1];
		oob_s3 <= oob_s2[MAX_ORDER-1];
	end

	// ---------------- -log2(a) ----------------
	logic        lg_v;
	logic [45:0] lg_nl;
	logic [66:0] lg_side;

	rqp_log #(
		.SW(67)
	) u_log (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s3),
		.a        (a_s3),
		.in_side  ({oob_s3, xp_s3, a_s3}),
		.out_valid(lg_v),
		.nlog     (lg_nl),
		.out_side (lg_side)
	);

	// ---------------- L = -log2(a) * ln2, and d = a * N ----------------
	logic        v_s4, oob_s4;
	logic [63:0] pl0_s4, pl1_s4;
	logic [45:0] pl2_s4, pl3_s4;
	logic [D_W-1:0] d_s4;
	logic [32:0] xp_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= lg_v;
		end
	end

	always_ff @(posedge clk) begin
		pl0_s4 <= 64'(lg_nl[31:0]) * 64'(LN2_Q64[31:0]);
		pl1_s4 <= 64'(lg_nl[31:0]) * 64'(LN2_Q64[63:32]);
		pl2_s4 <= 46'(lg_nl[45:32]) * 46'(LN2_Q64[31:0]);
		pl3_s4 <= 46'(lg_nl[45:32]) * 46'(LN2_Q64[63:32]);
		d_s4   <= D_W'(lg_side[32:0]) * D_W'(big_n);
		xp_s4  <= lg_side[65:33];
		oob_s4 <= lg_side[66];
	end

	logic [111:0] lnp;
	assign lnp = {2'b0, pl3_s4, 64'b0} + {16'b0, pl1_s4, 32'b0}
		+ {34'b0, pl2_s4, 32'b0} + {48'b0, pl0_s4};

	logic        v_s5, oob_s5;
	logic [45:0] lnv_s5;
	logic [D_W-1:0] d_s5;
	logic [32:0] xp_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		lnv_s5 <= lnp[109:64];
		d_s5   <= d_s4;
		xp_s5  <= xp_s4;
		oob_s5 <= oob_s4;
	end

	// ---------------- r = alpha * L in Q14.36 ----------------
	logic        v_s6, oob_s6;
	logic [63:0] ra0_s6;
	logic [45:0] ra1_s6;
	logic [D_W-1:0] d_s6;
	logic [32:0] xp_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		ra0_s6 <= 64'(radial_scale_q) * 64'(lnv_s5[31:0]);
		ra1_s6 <= 46'(radial_scale_q) * 46'(lnv_s5[45:32]);
		d_s6   <= d_s5;
		xp_s6  <= xp_s5;
		oob_s6 <= oob_s5;
	end

	logic [78:0] rp;
	assign rp = {1'b0, ra1_s6, 32'b0} + {15'b0, ra0_s6};

	logic        v_s7, oob_s7;
	logic [49:0] r_s7;
	logic [D_W-1:0] d_s7;
	logic [32:0] xp_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		r_s7   <= rp[77:28];
		d_s7   <= d_s6;
		xp_s7  <= xp_s6;
		oob_s7 <= oob_s6;
	end

	// ---------------- r^2, kept unclipped ----------------
	logic        v_s8, oob_s8, rsat_s8;
	logic [63:0] q0_s8;
	logic [49:0] q1_s8;
	logic [35:0] q2_s8;
	logic [RADIUS_W-1:0] rad_s8;
	logic [D_W-1:0] d_s8;
	logic [32:0] xp_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		q0_s8   <= 64'(r_s7[31:0]) * 64'(r_s7[31:0]);
		q1_s8   <= 50'(r_s7[49:32]) * 50'(r_s7[31:0]);
		q2_s8   <= 36'(r_s7[49:32]) * 36'(r_s7[49:32]);
		rad_s8  <= r_s7[RADIUS_W-1:0];
		rsat_s8 <= |r_s7[49:48];
		d_s8    <= d_s7;
		xp_s8   <= xp_s7;
		oob_s8  <= oob_s7;
	end

	// cross term counted twice: shift by 33
	logic [99:0] sq;
	assign sq = {q2_s8, 64'b0} + {17'b0, q1_s8, 33'b0} + {36'b0, q0_s8};

	logic        v_s9, oob_s9, rsat_s9;
	logic [63:0] s_s9;
	logic [RADIUS_W-1:0] rad_s9;
	logic [D_W-1:0] d_s9;
	logic [32:0] xp_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else begin
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		s_s9    <= sq[99:36];
		rad_s9  <= rad_s8;
		rsat_s9 <= rsat_s8;
		d_s9    <= d_s8;
		xp_s9   <= xp_s8;
		oob_s9  <= oob_s8;
	end

	// ---------------- s * x^(m-1) ----------------
	logic        v_s10, oob_s10, rsat_s10;
	logic [64:0] t0_s10, t1_s10;
	logic [RADIUS_W-1:0] rad_s10;
	logic [D_W-1:0] d_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
		end else begin
			v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		t0_s10   <= 65'(s_s9[31:0]) * 65'(xp_s9);
		t1_s10   <= 65'(s_s9[63:32]) * 65'(xp_s9);
		rad_s10  <= rad_s9;
		rsat_s10 <= rsat_s9;
		d_s10    <= d_s9;
		oob_s10  <= oob_s9;
	end

	logic [97:0] tp;
	assign tp = {1'b0, t1_s10, 32'b0} + {33'b0, t0_s10};

	logic        v_s11, oob_s11, rsat_s11;
	logic [63:0] s2_s11;
	logic [RADIUS_W-1:0] rad_s11;
	logic [D_W-1:0] d_s11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s11 <= 1'b0;
		end else begin
			v_s11 <= v_s10;
		end
	end

	always_ff @(posedge clk) begin
		s2_s11   <= tp[95:32];
		rad_s11  <= rad_s10;
		rsat_s11 <= rsat_s10;
		d_s11    <= d_s10;
		oob_s11  <= oob_s10;
	end

	// ---------------- numerator s * m * alpha * 2^12 ----------------
	logic        v_s12, oob_s12, rsat_s12;
	logic [67:0] u0_s12, u1_s12;
	logic [RADIUS_W-1:0] rad_s12;
	logic [D_W-1:0] d_s12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s12 <= 1'b0;
		end else begin
			v_s12 <= v_s11;
		end
	end

	always_ff @(posedge clk) begin
		u0_s12   <= 68'(s2_s11[31:0]) * 68'(mscale_q);
		u1_s12   <= 68'(s2_s11[63:32]) * 68'(mscale_q);
		rad_s12  <= rad_s11;
		rsat_s12 <= rsat_s11;
		d_s12    <= d_s11;
		oob_s12  <= oob_s11;
	end

	logic [99:0] up;
	assign up = {u1_s12, 32'b0} + {32'b0, u0_s12};

	// upper half at or above d means the quotient overflows 64 bits
	logic        v_s13, oob_s13, rsat_s13, wsat_s13;
	logic [47:0] phi_s13;
	logic [63:0] plo_s13;
	logic [RADIUS_W-1:0] rad_s13;
	logic [D_W-1:0] d_s13;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s13 <= 1'b0;
		end else begin
			v_s13 <= v_s12;
		end
	end

	always_ff @(posedge clk) begin
		phi_s13  <= up[99:52];
		plo_s13  <= {up[51:0], 12'b0};
		wsat_s13 <= up[99:52] >= {2'b0, d_s12};
		rad_s13  <= rad_s12;
		rsat_s13 <= rsat_s12;
		d_s13    <= d_s12;
		oob_s13  <= oob_s12;
	end

	// ---------------- weight divide by a * N ----------------
	logic               dw_v;
	logic [DIVW_NB-1:0] dw_q;
	logic [50:0]        dw_side;

	rqp_div #(
		.NB (DIVW_NB),
		.VW (D_W),
		.SPS(DIVW_SPS),
		.SW (51)
	) u_divw (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(v_s13),
		.rem_in  (wsat_s13 ? '0 : phi_s13[D_W-1:0]),
		.bits_in (plo_s13),
		.divisor (d_s13),
		.side_in ({oob_s13, rsat_s13, wsat_s13, rad_s13}),
		.out_valid(dw_v),
		.quot    (dw_q),
		.side_out(dw_side)
	);

	// ---------------- output register ----------------
	logic w_oob, w_rsat, w_clip;
	assign w_oob  = dw_side[50];
	assign w_rsat = dw_side[49];
	assign w_clip = dw_side[48] || dw_q[63];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= dw_v;
		end
	end

	always_ff @(posedge clk) begin
		radius    <= (w_oob || w_rsat) ? RADIUS_MAX : dw_side[RADIUS_W-1:0];
		weight    <= (w_oob || w_clip) ? WEIGHT_MAX : dw_q[WEIGHT_W-1:0];
		saturated <= w_oob || w_rsat || w_clip;
	end

	// ---------------- assertions ----------------
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LAT done)
		else $error("request did not complete at the fixed latency");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without a matching request");

	a_oob_sat: assert property (@(posedge clk) disable iff (!arst_n)
		v_s13 && oob_s13 |-> ##(DIVW_STG + 1) (done && saturated))
		else $error("index past grid end not flagged saturated");

endmodule

// ----- verif/radial_quadrature_point_test.sv -----
// Testbench for radial_quadrature_point: directed and random points checked against a predictor.
module radial_quadrature_point_test;
	import rqp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int PT_LIMIT    = 4096;
	localparam int ORD_LIMIT   = 8;
	localparam int LATENCY     = 146;
	localparam int CYCLE_LIMIT = 600000;

	// one expected radius/weight/saturated triple
	typedef struct {
		logic [RADIUS_W-1:0] radius;
		logic [WEIGHT_W-1:0] weight;
		logic                sat;
	} point_result_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_wen;
	logic [1:0]          cfg_index;
	logic [CFG_W-1:0]    cfg_wdata;
	logic                start;
	logic [INDEX_W-1:0]  point_index;
	logic                busy;
	logic                done;
	logic [RADIUS_W-1:0] radius;
	logic [WEIGHT_W-1:0] weight;
	logic                saturated;

	// predictor copy of the registers
	logic [GRID_W-1:0]  grid_q;
	logic [ORDER_W-1:0] order_q;
	logic [SCALE_W-1:0] scale_q;

	point_result_t pending_points[$];
	int  fail_count;
	int  checked_count;
	int  sat_count;
	int  sent_count;
	int  cycle_count;

	radial_quadrature_point dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.start(start), .point_index(point_index), .busy(busy),
		.done(done), .radius(radius), .weight(weight), .saturated(saturated)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// -log2(a / 2^32) in Q6.40, fraction bits by repeated squaring of a Q1.63 mantissa
	function automatic logic [63:0] neg_log2_q40(input logic [63:0] a);
		int unsigned  k;
		logic [63:0]  y;
		logic [63:0]  frac;
		logic [127:0] sq;
		k = 0;
		frac = '0;
		while (k < 32 && (a >> (k + 1)) != 0) k++;
		y = a << (63 - k);
		for (int i = 0; i < LOG_BITS; i++) begin
			sq = {64'd0, y} * {64'd0, y};
			frac = frac << 1;
			if (sq[127]) begin
				frac[0] = 1'b1;
				y = sq[127:64];
			end else begin
				y = sq[126:63];
			end
		end
		return (64'(32 - k) << LOG_BITS) - frac;
	endfunction

	// full grid point: abscissa from -alpha*ln(1-x^m), weight by a 128/64 divide
	function automatic point_result_t grid_point(input logic [INDEX_W-1:0] n);
		point_result_t res;
		logic [63:0]  big_n, m, x, xpow, xm, a, lnv, r, s, d, q;
		logic [127:0] wide;
		big_n = (grid_q > PT_LIMIT) ? 64'(PT_LIMIT) : 64'(grid_q);
		m = 64'(order_q);
		if (m == 0) m = 1;
		if (m > ORD_LIMIT) m = ORD_LIMIT;
		res.sat = 1'b0;
		// index past the end of the grid (covers a zero grid size too)
		if (64'(n) >= big_n) begin
			res.radius = RADIUS_MAX;
			res.weight = WEIGHT_MAX;
			res.sat = 1'b1;
			return res;
		end
		x = ((64'(n) * 2 + 1) << 31) / big_n;
		xpow = 64'(ONE_Q32);
		for (int i = 1; i < m; i++) xpow = (xpow * x) >> 32;
		xm = (xpow * x) >> 32;
		a = 64'(ONE_Q32) - xm;
		wide = {64'd0, neg_log2_q40(a)} * {64'd0, LN2_Q64};
		lnv = wide[127:64];
		wide = {96'd0, scale_q} * {64'd0, lnv};
		r = wide[91:28];
		if (r > 64'(RADIUS_MAX)) begin
			res.radius = RADIUS_MAX;
			res.sat = 1'b1;
		end else begin
			res.radius = r[RADIUS_W-1:0];
		end
		wide = {64'd0, r} * {64'd0, r};
		s = wide[99:36];
		wide = {64'd0, s} * {64'd0, xpow};
		s = wide[95:32];
		wide = {64'd0, s} * {64'd0, m * 64'(scale_q)};
		wide = wide << 12;
		d = a * big_n;
		if (wide[127:64] >= d) begin
			res.weight = WEIGHT_MAX;
			res.sat = 1'b1;
		end else begin
			wide = wide / {64'd0, d};
			q = wide[63:0];
			if (q > 64'(WEIGHT_MAX)) begin
				res.weight = WEIGHT_MAX;
				res.sat = 1'b1;
			end else begin
				res.weight = q[WEIGHT_W-1:0];
			end
		end
		return res;
	endfunction

	// result checker: every done pulse pops the oldest prediction
	always @(posedge clk) begin
		point_result_t want;
		if (arst_n && done) begin
			if (pending_points.size() == 0) begin
				$display("%0t: result with no request pending: radius %h weight %h sat %b",
					$time, radius, weight, saturated);
				fail_count++;
			end else begin
				want = pending_points.pop_front();
				checked_count++;
				if (want.sat) sat_count++;
				if (radius !== want.radius) begin
					$display("%0t: radius expected %h actual %h", $time, want.radius, radius);
					fail_count++;
				end
				if (weight !== want.weight) begin
					$display("%0t: weight expected %h actual %h", $time, want.weight, weight);
					fail_count++;
				end
				if (saturated !== want.sat) begin
					$display("%0t: saturated expected %b actual %b", $time, want.sat, saturated);
					fail_count++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, pending_points.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	// present one request and hold it until accepted; start stays high afterwards
	task automatic send_point(input logic [INDEX_W-1:0] n);
		@(negedge clk);
		start = 1'b1;
		point_index = n;
		do @(posedge clk); while (busy);
		pending_points.push_back(grid_point(n));
		sent_count++;
	endtask

	task automatic idle_cycles(input int cycles);
		@(negedge clk);
		start = 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	// hold off until every request has produced its result
	task automatic drain_points();
		idle_cycles(1);
		while (pending_points.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// registers change only with the pipeline empty
	task automatic write_reg(input reg_index_t idx, input logic [CFG_W-1:0] val);
		drain_points();
		cfg_wen = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_wen = 1'b0;
		case (idx)
			REG_GRID_SIZE:    grid_q = val[GRID_W-1:0];
			REG_POWER_ORDER:  order_q = val[ORDER_W-1:0];
			REG_RADIAL_SCALE: scale_q = val[SCALE_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_grid(input int grid, input int order, input logic [31:0] scale);
		write_reg(REG_GRID_SIZE, CFG_W'(grid));
		write_reg(REG_POWER_ORDER, CFG_W'(order));
		write_reg(REG_RADIAL_SCALE, scale);
	endtask

	// defaults after reset: 64 points, order 3, unit scale
	task automatic test_reset_defaults();
		send_point(0);
		send_point(1);
		send_point(63);
		send_point(64);
		send_point(12'hFFF);
		drain_points();
	endtask

	// extremes of every register and of the index
	task automatic test_directed_corners();
		set_grid(PT_LIMIT, ORD_LIMIT, 32'hFFFF_FFFF);
		send_point(0);
		send_point(12'hFFF);
		send_point(12'hAAA);
		set_grid(1, 1, 32'h0000_0001);
		send_point(0);
		send_point(1);
		// grid size zero: every index lies off the grid
		set_grid(0, 3, 32'h0100_0000);
		send_point(0);
		// grid size above the limit is clamped
		set_grid(8191, 0, 32'h0100_0000);
		send_point(12'hFFF);
		send_point(12'h555);
		// order above the limit is clamped, zero scale gives zero outputs for on-grid indices
		set_grid(17, 15, 32'h0000_0000);
		send_point(0);
		send_point(16);
		send_point(17);
		set_grid(4096, 1, 32'h8000_0000);
		send_point(4095);
		send_point(0);
		send_point(2048);
		drain_points();
	endtask

	// bursts of random indices, mostly on the grid
	task automatic run_random_points(input int count);
		int burst;
		int grid_eff;
		logic [INDEX_W-1:0] n;
		grid_eff = (grid_q > PT_LIMIT) ? PT_LIMIT : int'(grid_q);
		while (count > 0) begin
			burst = $urandom_range(1, 24);
			for (int i = 0; i < burst && count > 0; i++, count--) begin
				if (grid_eff == 0 || $urandom_range(0, 9) == 0) n = INDEX_W'($urandom());
				else n = INDEX_W'($urandom_range(0, grid_eff - 1));
				send_point(n);
			end
			if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(0, 12));
		end
	endtask

	// a sweep of register settings with random points under each
	task automatic test_random_sweep();
		logic [31:0] scale;
		for (int phase = 0; phase < 12; phase++) begin
			case ($urandom_range(0, 3))
				0: scale = 32'h0100_0000;
				1: scale = $urandom_range(32'h0040_0000, 32'h0800_0000);
				2: scale = (phase == 3) ? 32'hFFFF_FFFF : $urandom();
				default: scale = $urandom_range(0, 32'h0000_FFFF);
			endcase
			case (phase)
				0: set_grid(PT_LIMIT, ORD_LIMIT, scale);
				1: set_grid(1, 1, scale);
				2: set_grid(8191, 0, scale);
				3: set_grid(PT_LIMIT, 15, 32'hFFFF_FFFF);
				default: set_grid($urandom_range(1, 4200), $urandom_range(0, 15), scale);
			endcase
			run_random_points(80);
			// let the pipeline empty completely once per phase
			drain_points();
			run_random_points(80);
		end
		drain_points();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_index = REG_GRID_SIZE;
		cfg_wdata = '0;
		start = 1'b0;
		point_index = '0;
		grid_q = GRID_RST;
		order_q = ORDER_RST;
		scale_q = SCALE_RST;
		fail_count = 0;
		checked_count = 0;
		sat_count = 0;
		sent_count = 0;
		cycle_count = 0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_defaults();
		test_directed_corners();
		test_random_sweep();

		repeat (LATENCY + 20) @(negedge clk);
		$display("Sent %0d grid point requests, checked %0d results (%0d clipped)",
			sent_count, checked_count, sat_count);
		$display("Register sweep covered grid sizes 0..8191, orders 0..15, scales 0..max");
		if (fail_count == 0 && pending_points.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
